@@ rtl/mexp_pkg.sv @@
// Package for the modular exponentiation block: widths, controller states, multiplier structs.
package mexp_pkg;

  // Width of every payload field on the channels
  localparam int unsigned MEXP_FIELD_WIDTH   = 32;
  // Default width of the arithmetic
  localparam int unsigned MEXP_OPERAND_WIDTH = 32;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RWAIT,
    S_CHECK,
    S_MWAIT,
    S_DONE
  } mexp_state_t;

  // Control into the serial modular multiplier
  typedef struct packed {
    logic start;
  } mexp_mul_ctrl_t;

  // Status back from the serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

@@ rtl/mexp_if.sv @@
// Valid/ready channel interfaces for the operand and result transactions.
interface mexp_in_if
  import mexp_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [MEXP_FIELD_WIDTH-1:0] base;
  logic [MEXP_FIELD_WIDTH-1:0] exponent;
  logic [MEXP_FIELD_WIDTH-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if
  import mexp_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [MEXP_FIELD_WIDTH-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

@@ rtl/mexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = MEXP_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mexp_mul_ctrl_t           ctrl,
  input  logic [OPERAND_WIDTH-1:0] mul_a,
  input  logic [OPERAND_WIDTH-1:0] mul_b,
  input  logic [OPERAND_WIDTH-1:0] mul_m,
  output mexp_mul_stat_t           stat,
  output logic [OPERAND_WIDTH-1:0] product
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W+1:0]  sum;
  logic [W+1:0]  red1;
  logic [W+1:0]  m_ext;

  // One step: acc = (2*acc + bit*a) mod m; the sum stays below 3m
  always_comb begin
    m_ext = {2'b00, m_r};
    sum   = {1'b0, acc_r, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : '0);
    red1  = (sum >= m_ext) ? sum - m_ext : sum;
    acc_nxt = (red1 >= m_ext) ? W'(red1 - m_ext) : W'(red1);
  end

  // Operand shift and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.start && !busy_r) begin
      acc_r <= '0;
      a_r   <= mul_a;
      b_r   <= mul_b;
      m_r   <= mul_m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: controller around the serial multiplier.
//
// Use: an operand transaction (base, exponent, modulus) enters on in_ch; one
// transaction carrying power_result = base^exponent mod modulus leaves on out_ch.
// Arithmetic runs on the low OPERAND_WIDTH (W) bits of every field.
// Sequence: the base is first reduced by one pass of the multiplier, then each
// exponent step costs one check state plus one multiply pass.
// Up to 2*W-1 steps are needed, so the time from acceptance to a valid result
// grows with the exponent and is shortest for a zero exponent. Each pass uses
// the shared bit-serial modular multiplier, which sets the pace; the
// loop stops early once the running power reaches 0 or 1.
// One item is in work at a time; in_ch.ready is high while the controller idles.
// A finished result sits in the output register, and the next item is accepted
// while it waits; if the receiver still stalls when that item finishes, the
// controller holds in its final state until the register frees.
// Reset (rst_n low, synchronous) empties the output register and returns the
// controller to idle. Modulus 1 gives 0; modulus 0 gives 0.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = MEXP_OPERAND_WIDTH
) (
  input logic        clk,
  input logic        rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch
);

  localparam int unsigned W = OPERAND_WIDTH;

  mexp_state_t state_r, state_nxt;

  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] pw_r, pw_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic [W-1:0] m_r;
  logic         sq_r, sq_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [MEXP_FIELD_WIDTH-1:0] out_data_r, out_data_nxt;

  mexp_mul_ctrl_t mul_ctrl;
  mexp_mul_stat_t mul_stat;
  logic [W-1:0]   mul_a, mul_b;
  logic [W-1:0]   product;

  logic in_accept;
  logic out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  mexp_mulmod #(
    .OPERAND_WIDTH(W)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mul_ctrl),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_m   (m_r),
    .stat    (mul_stat),
    .product (product)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = (m_r == '0) ? S_DONE : S_RWAIT;
      S_RWAIT: if (mul_stat.done) state_nxt = S_CHECK;
      S_CHECK: begin
        if (exp_r == '0 || pw_r == '0 || pw_r == W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MWAIT;
        end
      end
      S_MWAIT: if (mul_stat.done) state_nxt = S_CHECK;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    acc_nxt       = acc_r;
    pw_nxt        = pw_r;
    exp_nxt       = exp_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    mul_ctrl      = '0;
    mul_a         = acc_r;
    mul_b         = pw_r;
    case (state_r)
      S_LOAD: begin
        // base mod m, taken as base * 1 through the multiplier
        mul_ctrl.start = (m_r != '0);
        mul_a          = W'(1);
        mul_b          = pw_r;
        if (m_r == '0) acc_nxt = '0;
      end
      S_RWAIT: if (mul_stat.done) pw_nxt = product;
      S_CHECK: begin
        if (exp_r == '0 || pw_r == W'(1)) begin
          acc_nxt = acc_r;
        end else if (pw_r == '0) begin
          acc_nxt = '0;
        end else begin
          mul_ctrl.start = 1'b1;
          sq_nxt         = !exp_r[0];
          mul_a          = exp_r[0] ? acc_r : pw_r;
          mul_b          = pw_r;
        end
      end
      S_MWAIT: begin
        if (mul_stat.done) begin
          if (sq_r) begin
            pw_nxt  = product;
            exp_nxt = {1'b0, exp_r[W-1:1]};
          end else begin
            acc_nxt    = product;
            exp_nxt[0] = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = MEXP_FIELD_WIDTH'(acc_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sq_r       <= sq_nxt;
    if (in_accept) begin
      pw_r  <= in_ch.base[W-1:0];
      exp_r <= in_ch.exponent[W-1:0];
      m_r   <= in_ch.modulus[W-1:0];
      // result starts at 1 mod m
      acc_r <= (in_ch.modulus[W-1:0] == W'(1)) ? '0 : W'(1);
    end else begin
      pw_r  <= pw_nxt;
      exp_r <= exp_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_result = out_data_r;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctrl.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_product_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_stat.done && m_r != '0) |-> (product < m_r))
    else $error("multiplier product not reduced");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (acc_r < m_r))
    else $error("accumulator not below modulus");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_LOAD))
    else $error("accepted transaction did not start");

  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWAIT && !mul_stat.done) |-> mul_stat.busy)
    else $error("waiting on an idle multiplier");

endmodule

@@ test/mexp_checker.sv @@
// Checker for the modular exponentiation block: predicts each power and compares the results.
`timescale 1ns / 1ps

module mexp_checker
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = MEXP_OPERAND_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  mexp_in_if          in_mon,
  mexp_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef logic [MEXP_FIELD_WIDTH-1:0] field_t;

  // Operands kept beside each predicted power for the mismatch report
  typedef struct packed {
    field_t base;
    field_t exponent;
    field_t modulus;
    field_t power_result;
  } power_job_t;

  power_job_t pending_powers[$];

  // Right-to-left square-and-multiply on the low OPERAND_WIDTH bits
  function automatic field_t predict_power(input field_t b_in, input field_t e_in,
                                           input field_t m_in);
    logic [63:0] mask;
    logic [63:0] acc;
    logic [63:0] pw;
    logic [63:0] e;
    logic [63:0] m;
    mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
    e    = {32'd0, e_in} & mask;
    m    = {32'd0, m_in} & mask;
    acc  = 64'd1;
    if (m == 64'd0) return '0;
    pw = ({32'd0, b_in} & mask) % m;
    while (e > 64'd0) begin
      // running power stuck at 0 or 1: nothing more changes
      if (pw == 64'd0) begin
        acc = 64'd0;
        break;
      end
      if (pw == 64'd1) break;
      if (e[0]) begin
        acc = (acc * pw) % m;
        e   = e - 64'd1;
      end else begin
        pw = (pw * pw) % m;
        e  = e >> 1;
      end
    end
    acc = acc % m;
    return acc[MEXP_FIELD_WIDTH-1:0];
  endfunction

  // Record accepted operands, check accepted results against the oldest prediction
  always @(posedge clk) begin
    power_job_t job;
    if (!rst_n) begin
      pending_powers.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        job.base         = in_mon.base;
        job.exponent     = in_mon.exponent;
        job.modulus      = in_mon.modulus;
        job.power_result = predict_power(in_mon.base, in_mon.exponent, in_mon.modulus);
        pending_powers.insert(pending_powers.size(), job);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_powers.size() == 0) begin
          $error("power_result: expected none, actual %h", out_mon.power_result);
          fail_count <= fail_count + 1;
        end else begin
          job = pending_powers.pop_front();
          if (out_mon.power_result !== job.power_result) begin
            $error("power_result: expected %h, actual %h (base %h exponent %h modulus %h)",
                   job.power_result, out_mon.power_result, job.base, job.exponent,
                   job.modulus);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= pending_powers.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the modular exponentiation block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
  import mexp_pkg::*;
();

  localparam int unsigned HOLD_CYCLES     = 6000;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned PRESSURE_ITEMS  = 10;
  localparam int unsigned DRAIN_CYCLES    = 50;

  typedef logic [MEXP_FIELD_WIDTH-1:0] field_t;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH,
    PH_PRESSURE
  } tb_phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  tb_phase_t   phase;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned hold_count;
  bit          hold_done;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  always #2 clk = ~clk;

  modular_exponentiation #(
    .OPERAND_WIDTH(MEXP_OPERAND_WIDTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  mexp_checker #(
    .OPERAND_WIDTH(MEXP_OPERAND_WIDTH)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Result side: free, random stalls, or one long hold-off under pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_count   <= 0;
      hold_done    <= 1'b0;
    end else if (phase == PH_PRESSURE && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_count   <= hold_count + 1;
      if (hold_count + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      case (phase)
        PH_SNK_STALL: begin
          out_ch.ready <= ($urandom_range(99) >= 75);
        end
        PH_BOTH: begin
          out_ch.ready <= ($urandom_range(99) >= 10);
        end
        default: begin
          out_ch.ready <= 1'b1;
        end
      endcase
    end
  end

  // Offer one operand transaction, with a random gap first, and wait for acceptance
  task automatic send_operands(input field_t b, input field_t e, input field_t m);
    int unsigned idle_pct;
    idle_pct = (phase == PH_SRC_IDLE) ? 75 : (phase == PH_BOTH) ? 10 : 0;
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.base     <= b;
    in_ch.exponent <= e;
    in_ch.modulus  <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Random operands; short_exp forces a short exponent, which keeps an item quick
  task automatic send_random(input bit short_exp);
    field_t      b;
    field_t      e;
    field_t      m;
    int unsigned pick;
    b    = $urandom;
    e    = $urandom;
    m    = $urandom;
    pick = $urandom_range(99);
    if (short_exp || pick < 40) e = $urandom_range(255);
    else if (pick < 45) e = '1;
    if (pick >= 80 && pick < 90) m = $urandom_range(16, 1);
    else if (pick >= 90 && pick < 93) m = 32'd1;
    else if (pick >= 93 && pick < 96) b = '0;
    else if (pick >= 96) b = '1;
    if (m == '0) m = 32'd1;
    send_operands(b, e, m);
  endtask

  initial begin
    rst_n          <= 1'b0;
    phase          <= PH_FREE;
    in_ch.valid    <= 1'b0;
    in_ch.base     <= '0;
    in_ch.exponent <= '0;
    in_ch.modulus  <= 32'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero exponent, zero and unit running power, modulus one, extremes
    send_operands(32'd0,          32'd0,          32'd1);
    send_operands(32'd5,          32'd0,          32'd7);
    send_operands(32'hFFFFFFFF,   32'd0,          32'hFFFFFFFF);
    send_operands(32'd5,          32'd0,          32'd1);
    send_operands(32'hFFFFFFFF,   32'hFFFFFFFF,   32'd1);
    send_operands(32'd0,          32'd5,          32'd7);
    send_operands(32'd0,          32'd0,          32'd7);
    send_operands(32'd14,         32'd3,          32'd7);
    send_operands(32'd1,          32'hFFFFFFFF,   32'hFFFFFFFF);
    send_operands(32'd8,          32'd9,          32'd7);
    send_operands(32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF);
    send_operands(32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFE);
    send_operands(32'hFFFFFFFE,   32'd2,          32'hFFFFFFFF);
    send_operands(32'd2,          32'd31,         32'hFFFFFFFF);
    send_operands(32'd3,          32'hFFFFFFFF,   32'h7FFFFFFF);
    send_operands(32'h80000000,   32'd2,          32'hFFFFFFFB);
    send_operands(32'd12345,      32'd65537,      32'hFFFFFFFB);
    send_operands(32'h075BCD15,   32'hAAAAAAAA,   32'h55555555);
    send_operands(32'h55555555,   32'h55555555,   32'hAAAAAAAA);
    send_operands(32'd3,          32'd5,          32'd2);
    send_operands(32'd2,          32'd10,         32'd1000);

    // Random items under each idling pattern
    for (int p = 0; p < 4; p++) begin
      phase <= tb_phase_t'(p);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) send_random(1'b0);
    end

    // Receiver holds off while operands keep coming, so the input stalls
    phase <= PH_PRESSURE;
    for (int unsigned i = 0; i < PRESSURE_ITEMS; i++) send_random(1'b1);

    phase       <= PH_FREE;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[modular_exponentiation] ERROR");
    $finish;
  end

endmodule
